>>> rtl/tfc_pkg.sv
// Shared widths, register indexes and pipeline control type for the triangle flip check.
`default_nettype none

package tfc_pkg;

	localparam int COORD_W     = 16;
	localparam int INDEX_W     = 24;
	localparam int EDGE_W      = COORD_W + 1;
	localparam int MAG_W       = 34;
	localparam int HALF_W      = MAG_W / 2;
	localparam int PROD_W      = 2 * MAG_W;
	localparam int LIMB_W      = 24;
	localparam int WIDE_W      = 3 * LIMB_W;
	localparam int WIDE_PROD_W = 2 * WIDE_W;
	localparam int SUM_W       = PROD_W + 2;

	typedef enum logic [2:0] {
		REG_MOVING_INDEX = 3'd0,
		REG_OLD_X        = 3'd1,
		REG_OLD_Y        = 3'd2,
		REG_OLD_Z        = 3'd3,
		REG_NEW_X        = 3'd4,
		REG_NEW_Y        = 3'd5,
		REG_NEW_Z        = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic vld;
		logic touch;
		logic degen;
		logic neg;
	} ctl_t;

endpackage

`default_nettype wire

>>> rtl/tfc_mul34.sv
// Two-stage unsigned 34 x 34 multiplier built from 17 x 17-bit partial products.
`default_nettype none

module tfc_mul34 (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [tfc_pkg::MAG_W-1:0]  a,
	input  wire logic [tfc_pkg::MAG_W-1:0]  b,
	output logic      [tfc_pkg::PROD_W-1:0] p
);
	import tfc_pkg::*;

	logic [MAG_W-1:0] pp_s1 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s1[0] <= a[HALF_W-1:0] * b[HALF_W-1:0];
			pp_s1[1] <= a[HALF_W-1:0] * b[MAG_W-1:HALF_W];
			pp_s1[2] <= a[MAG_W-1:HALF_W] * b[HALF_W-1:0];
			pp_s1[3] <= a[MAG_W-1:HALF_W] * b[MAG_W-1:HALF_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= PROD_W'(pp_s1[0])
				+ ((PROD_W'(pp_s1[1]) + PROD_W'(pp_s1[2])) << HALF_W)
				+ (PROD_W'(pp_s1[3]) << MAG_W);
		end
	end

endmodule

`default_nettype wire

>>> rtl/tfc_mul72.sv
// Four-stage unsigned 72 x 72 multiplier built from 24-bit limb products.
`default_nettype none

module tfc_mul72 (
	input  wire logic                            clk,
	input  wire logic                            en,
	input  wire logic [tfc_pkg::WIDE_W-1:0]      a,
	input  wire logic [tfc_pkg::WIDE_W-1:0]      b,
	output logic      [tfc_pkg::WIDE_PROD_W-1:0] p
);
	import tfc_pkg::*;

	localparam int PP_W  = 2 * LIMB_W;
	localparam int COL_W = PP_W + 2;

	logic [PP_W-1:0]        pp_s1 [3][3];
	logic [COL_W-1:0]       col_s2 [5];
	logic [WIDE_PROD_W-1:0] even_s3;
	logic [WIDE_PROD_W-1:0] odd_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pp_s1[i][j] <= a[LIMB_W*i +: LIMB_W] * b[LIMB_W*j +: LIMB_W];
				end
			end
		end
	end

	// gather partial products of equal weight
	always_ff @(posedge clk) begin
		if (en) begin
			col_s2[0] <= COL_W'(pp_s1[0][0]);
			col_s2[1] <= COL_W'(pp_s1[0][1]) + COL_W'(pp_s1[1][0]);
			col_s2[2] <= COL_W'(pp_s1[0][2]) + COL_W'(pp_s1[1][1]) + COL_W'(pp_s1[2][0]);
			col_s2[3] <= COL_W'(pp_s1[1][2]) + COL_W'(pp_s1[2][1]);
			col_s2[4] <= COL_W'(pp_s1[2][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			even_s3 <= WIDE_PROD_W'(col_s2[0])
				+ (WIDE_PROD_W'(col_s2[2]) << (2 * LIMB_W))
				+ (WIDE_PROD_W'(col_s2[4]) << (4 * LIMB_W));
			odd_s3  <= (WIDE_PROD_W'(col_s2[1]) << LIMB_W)
				+ (WIDE_PROD_W'(col_s2[3]) << (3 * LIMB_W));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= even_s3 + odd_s3;
		end
	end

endmodule

`default_nettype wire

>>> rtl/triangle_flip_check.sv
// Top level: streaming normal flip test for triangles around a moving vertex.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+------------------------------------------
//  in       | in_valid / in_stall            | three corner indices, nine Q8.8 coordinates
//  out      | out_valid / out_stall          | flips, touches_mover
//  config   | wr_en, wr_index, wr_data       | moving index, old and new position
//
//  One triangle a cycle enters unless the pipe is stalled; the pipe depth is set
//  by the two chained wide multipliers (34 x 34 for dot and lengths, 72 x 72 for the
//  squared compare). Reset clears the valid bits and the configuration registers.
//  A stalled result freezes the whole pipe, so in_stall follows out_stall while a
//  result is held; no transaction is lost or repeated.
`default_nettype none

module triangle_flip_check (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [tfc_pkg::INDEX_W-1:0]   first_corner,
	input  wire logic [tfc_pkg::INDEX_W-1:0]   second_corner,
	input  wire logic [tfc_pkg::INDEX_W-1:0]   third_corner,
	input  wire logic signed [tfc_pkg::COORD_W-1:0] first_px,
	input  wire logic signed [tfc_pkg::COORD_W-1:0] first_py,
	input  wire logic signed [tfc_pkg::COORD_W-1:0] first_pz,
	input  wire logic signed [tfc_pkg::COORD_W-1:0] second_px,
	input  wire logic signed [tfc_pkg::COORD_W-1:0] second_py,
	input  wire logic signed [tfc_pkg::COORD_W-1:0] second_pz,
	input  wire logic signed [tfc_pkg::COORD_W-1:0] third_px,
	input  wire logic signed [tfc_pkg::COORD_W-1:0] third_py,
	input  wire logic signed [tfc_pkg::COORD_W-1:0] third_pz,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               flips,
	output logic                               touches_mover,
	input  wire logic                          wr_en,
	input  wire logic [2:0]                    wr_index,
	input  wire logic [tfc_pkg::INDEX_W-1:0]   wr_data
);
	import tfc_pkg::*;

	localparam int TERM_W = 2 * EDGE_W;
	localparam int CROSS_W = TERM_W + 1;

	function automatic logic signed [EDGE_W-1:0] sx(input logic signed [COORD_W-1:0] v);
		return {v[COORD_W-1], v};
	endfunction

	function automatic logic signed [TERM_W-1:0] smul(input logic signed [EDGE_W-1:0] x,
	                                                  input logic signed [EDGE_W-1:0] y);
		return x * y;
	endfunction

	function automatic logic signed [CROSS_W-1:0] sdiff(input logic signed [TERM_W-1:0] x,
	                                                    input logic signed [TERM_W-1:0] y);
		logic signed [CROSS_W-1:0] xe;
		logic signed [CROSS_W-1:0] ye;
		xe = {x[TERM_W-1], x};
		ye = {y[TERM_W-1], y};
		return xe - ye;
	endfunction

	function automatic logic [MAG_W-1:0] mag(input logic signed [CROSS_W-1:0] v);
		logic signed [CROSS_W-1:0] t;
		t = v[CROSS_W-1] ? -v : v;
		return t[MAG_W-1:0];
	endfunction

	// configuration
	logic [INDEX_W-1:0]        moving_index_q;
	logic signed [COORD_W-1:0] old_q [3];
	logic signed [COORD_W-1:0] new_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_index_q <= '0;
			for (int c = 0; c < 3; c++) begin
				old_q[c] <= '0;
				new_q[c] <= '0;
			end
		end else if (wr_en) begin
			case (wr_index)
				REG_MOVING_INDEX: moving_index_q <= wr_data;
				REG_OLD_X:        old_q[0] <= wr_data[COORD_W-1:0];
				REG_OLD_Y:        old_q[1] <= wr_data[COORD_W-1:0];
				REG_OLD_Z:        old_q[2] <= wr_data[COORD_W-1:0];
				REG_NEW_X:        new_q[0] <= wr_data[COORD_W-1:0];
				REG_NEW_Y:        new_q[1] <= wr_data[COORD_W-1:0];
				REG_NEW_Z:        new_q[2] <= wr_data[COORD_W-1:0];
				default:          ;
			endcase
		end
	end

	// pipeline control
	logic en;
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	ctl_t ctl_s8, ctl_s9, ctl_s10, ctl_s11, ctl_s12, ctl_s13;

	assign en = !(ctl_s13.vld && out_stall);
	assign in_stall = !en;

	// stage 1: substitute positions and form edge vectors
	logic [2:0]                hit;
	logic [2:0]                first_hit;
	logic signed [COORD_W-1:0] pin [3][3];
	logic signed [COORD_W-1:0] po [3][3];
	logic signed [COORD_W-1:0] pn [3][3];
	logic signed [EDGE_W-1:0]  eao_s1 [3];
	logic signed [EDGE_W-1:0]  ebo_s1 [3];
	logic signed [EDGE_W-1:0]  ean_s1 [3];
	logic signed [EDGE_W-1:0]  ebn_s1 [3];

	assign pin[0][0] = first_px;
	assign pin[0][1] = first_py;
	assign pin[0][2] = first_pz;
	assign pin[1][0] = second_px;
	assign pin[1][1] = second_py;
	assign pin[1][2] = second_pz;
	assign pin[2][0] = third_px;
	assign pin[2][1] = third_py;
	assign pin[2][2] = third_pz;

	always_comb begin
		hit[0] = first_corner == moving_index_q;
		hit[1] = second_corner == moving_index_q;
		hit[2] = third_corner == moving_index_q;
		// only the first matching corner moves to the new position
		first_hit[0] = hit[0];
		first_hit[1] = hit[1] && !hit[0];
		first_hit[2] = hit[2] && !hit[1] && !hit[0];
		for (int k = 0; k < 3; k++) begin
			for (int c = 0; c < 3; c++) begin
				po[k][c] = hit[k] ? old_q[c] : pin[k][c];
				pn[k][c] = first_hit[k] ? new_q[c] : po[k][c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				eao_s1[c] <= sx(po[1][c]) - sx(po[0][c]);
				ebo_s1[c] <= sx(po[2][c]) - sx(po[0][c]);
				ean_s1[c] <= sx(pn[1][c]) - sx(pn[0][c]);
				ebn_s1[c] <= sx(pn[2][c]) - sx(pn[0][c]);
			end
		end
	end

	// stage 2: cross-product terms
	logic signed [TERM_W-1:0] to_s2 [6];
	logic signed [TERM_W-1:0] tn_s2 [6];

	always_ff @(posedge clk) begin
		if (en) begin
			to_s2[0] <= smul(eao_s1[1], ebo_s1[2]);
			to_s2[1] <= smul(eao_s1[2], ebo_s1[1]);
			to_s2[2] <= smul(eao_s1[2], ebo_s1[0]);
			to_s2[3] <= smul(eao_s1[0], ebo_s1[2]);
			to_s2[4] <= smul(eao_s1[0], ebo_s1[1]);
			to_s2[5] <= smul(eao_s1[1], ebo_s1[0]);
			tn_s2[0] <= smul(ean_s1[1], ebn_s1[2]);
			tn_s2[1] <= smul(ean_s1[2], ebn_s1[1]);
			tn_s2[2] <= smul(ean_s1[2], ebn_s1[0]);
			tn_s2[3] <= smul(ean_s1[0], ebn_s1[2]);
			tn_s2[4] <= smul(ean_s1[0], ebn_s1[1]);
			tn_s2[5] <= smul(ean_s1[1], ebn_s1[0]);
		end
	end

	// stage 3: normals
	logic signed [CROSS_W-1:0] no_s3 [3];
	logic signed [CROSS_W-1:0] nn_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				no_s3[c] <= sdiff(to_s2[2*c], to_s2[2*c+1]);
				nn_s3[c] <= sdiff(tn_s2[2*c], tn_s2[2*c+1]);
			end
		end
	end

	// stage 4: sign and magnitude, degenerate test
	logic [MAG_W-1:0] mo_s4 [3];
	logic [MAG_W-1:0] mn_s4 [3];
	logic [2:0]       sgn_s4, sgn_s5, sgn_s6;
	logic             degen;

	assign degen = (no_s3[0] == '0 && no_s3[1] == '0 && no_s3[2] == '0)
		|| (nn_s3[0] == '0 && nn_s3[1] == '0 && nn_s3[2] == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				mo_s4[c]  <= mag(no_s3[c]);
				mn_s4[c]  <= mag(nn_s3[c]);
				sgn_s4[c] <= no_s3[c][CROSS_W-1] ^ nn_s3[c][CROSS_W-1];
			end
			sgn_s5 <= sgn_s4;
			sgn_s6 <= sgn_s5;
		end
	end

	// stages 5 and 6: component products
	logic [PROD_W-1:0] pd_s6 [3];
	logic [PROD_W-1:0] plo_s6 [3];
	logic [PROD_W-1:0] pln_s6 [3];

	for (genvar c = 0; c < 3; c++) begin : g_comp
		tfc_mul34 u_dot (.clk(clk), .en(en), .a(mo_s4[c]), .b(mn_s4[c]), .p(pd_s6[c]));
		tfc_mul34 u_lo  (.clk(clk), .en(en), .a(mo_s4[c]), .b(mo_s4[c]), .p(plo_s6[c]));
		tfc_mul34 u_ln  (.clk(clk), .en(en), .a(mn_s4[c]), .b(mn_s4[c]), .p(pln_s6[c]));
	end

	// stage 7: dot product and squared lengths
	logic signed [SUM_W-1:0] term [3];
	logic signed [SUM_W-1:0] dot_s7;
	logic [SUM_W-1:0]        lo_s7;
	logic [SUM_W-1:0]        ln_s7;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			term[c] = sgn_s6[c] ? -$signed(SUM_W'(pd_s6[c])) : $signed(SUM_W'(pd_s6[c]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s7 <= term[0] + term[1] + term[2];
			lo_s7  <= SUM_W'(plo_s6[0]) + SUM_W'(plo_s6[1]) + SUM_W'(plo_s6[2]);
			ln_s7  <= SUM_W'(pln_s6[0]) + SUM_W'(pln_s6[1]) + SUM_W'(pln_s6[2]);
		end
	end

	// stages 8 to 11: dot squared and length product; a negative dot is flagged anyway
	logic [WIDE_PROD_W-1:0] dd_s11;
	logic [WIDE_PROD_W-1:0] ll_s11;

	tfc_mul72 u_dd (
		.clk(clk), .en(en),
		.a(WIDE_W'(unsigned'(dot_s7))), .b(WIDE_W'(unsigned'(dot_s7))), .p(dd_s11)
	);
	tfc_mul72 u_ll (
		.clk(clk), .en(en),
		.a(WIDE_W'(lo_s7)), .b(WIDE_W'(ln_s7)), .p(ll_s11)
	);

	// stage 12: scale by 25 = 16 + 8 + 1
	logic [WIDE_PROD_W:0] lhs_s12;
	logic [WIDE_PROD_W:0] rhs_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			lhs_s12 <= ({1'b0, dd_s11} << 4) + ({1'b0, dd_s11} << 3) + {1'b0, dd_s11};
			rhs_s12 <= {1'b0, ll_s11};
		end
	end

	// stage 13: output register
	logic flips_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			flips_s13 <= ctl_s12.touch && !ctl_s12.degen
				&& (ctl_s12.neg || (lhs_s12 < rhs_s12));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			ctl_s3  <= '0;
			ctl_s4  <= '0;
			ctl_s5  <= '0;
			ctl_s6  <= '0;
			ctl_s7  <= '0;
			ctl_s8  <= '0;
			ctl_s9  <= '0;
			ctl_s10 <= '0;
			ctl_s11 <= '0;
			ctl_s12 <= '0;
			ctl_s13 <= '0;
		end else if (en) begin
			ctl_s1  <= '{vld: in_valid, touch: |hit, degen: 1'b0, neg: 1'b0};
			ctl_s2  <= ctl_s1;
			ctl_s3  <= ctl_s2;
			ctl_s4  <= '{vld: ctl_s3.vld, touch: ctl_s3.touch, degen: degen, neg: 1'b0};
			ctl_s5  <= ctl_s4;
			ctl_s6  <= ctl_s5;
			ctl_s7  <= ctl_s6;
			ctl_s8  <= '{vld: ctl_s7.vld, touch: ctl_s7.touch, degen: ctl_s7.degen,
			             neg: dot_s7[SUM_W-1]};
			ctl_s9  <= ctl_s8;
			ctl_s10 <= ctl_s9;
			ctl_s11 <= ctl_s10;
			ctl_s12 <= ctl_s11;
			ctl_s13 <= ctl_s12;
		end
	end

	assign out_valid     = ctl_s13.vld;
	assign flips         = flips_s13;
	assign touches_mover = ctl_s13.touch;

	a_no_touch_no_flip: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s13.vld && !ctl_s13.touch |-> !flips_s13)
		else $error("flip reported for a triangle away from the mover");

	a_degen_no_flip: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s13.vld && ctl_s13.degen |-> !flips_s13)
		else $error("flip reported for a degenerate triangle");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s13.vld && out_stall |=> $stable(ctl_s7) && $stable(ctl_s1))
		else $error("pipeline moved while the result was stalled");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ctl_s1.vld)
		else $error("accepted transaction missing from first stage");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the triangle flip check: directed corner cases, then random triangles.
`timescale 1ns / 100ps

module testbench;
	import tfc_pkg::*;

	localparam int          CYCLE_LIMIT = 500000;
	localparam int          DRAIN_CYCLES = 20;
	localparam logic [2:0]  REG_UNUSED = 3'd7;

	typedef logic [2:0][63:0] vec3_t;

	typedef struct packed {
		logic [2:0][INDEX_W-1:0] corner;
		logic [8:0][COORD_W-1:0] coord;
	} triangle_t;

	typedef struct packed {
		logic flips;
		logic touches;
	} verdict_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [INDEX_W-1:0]         first_corner, second_corner, third_corner;
	logic signed [COORD_W-1:0]  first_px, first_py, first_pz;
	logic signed [COORD_W-1:0]  second_px, second_py, second_pz;
	logic signed [COORD_W-1:0]  third_px, third_py, third_pz;
	logic                       out_valid;
	logic                       out_stall;
	logic                       flips;
	logic                       touches_mover;
	logic                       wr_en;
	logic [2:0]                 wr_index;
	logic [INDEX_W-1:0]         wr_data;

	// register shadow
	logic [INDEX_W-1:0]         cfg_index;
	logic signed [COORD_W-1:0]  cfg_from [3];
	logic signed [COORD_W-1:0]  cfg_to [3];

	triangle_t  triangle_queue [$];
	verdict_t   verdict_queue [$];
	triangle_t  on_bus;
	verdict_t   want;
	logic       tri_taken;
	logic       no_idle;
	int         in_gap;
	int         out_hold;
	int         mismatches;
	int         cycle_count;

	triangle_flip_check i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.first_corner  (first_corner),
		.second_corner (second_corner),
		.third_corner  (third_corner),
		.first_px      (first_px),
		.first_py      (first_py),
		.first_pz      (first_pz),
		.second_px     (second_px),
		.second_py     (second_py),
		.second_pz     (second_pz),
		.third_px      (third_px),
		.third_py      (third_py),
		.third_pz      (third_pz),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.flips         (flips),
		.touches_mover (touches_mover),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	always #4 clk = ~clk;

	function automatic vec3_t normal_of(vec3_t p0, vec3_t p1, vec3_t p2);
		longint ax, ay, az, bx, by, bz;
		vec3_t n;
		ax = p1[0] - p0[0];
		ay = p1[1] - p0[1];
		az = p1[2] - p0[2];
		bx = p2[0] - p0[0];
		by = p2[1] - p0[1];
		bz = p2[2] - p0[2];
		n[0] = ay * bz - az * by;
		n[1] = az * bx - ax * bz;
		n[2] = ax * by - ay * bx;
		return n;
	endfunction

	function automatic verdict_t judge_triangle(triangle_t t);
		logic [2:0][2:0][63:0] pt;
		logic [2:0]            hit;
		vec3_t                 na, nb;
		longint                sv;
		logic signed [191:0]   dot, len_a, len_b, wa, wb;
		verdict_t              v;
		int                    k, c, first;
		v = '0;
		first = 0;
		for (k = 0; k < 3; k++) begin
			hit[k] = (t.corner[k] == cfg_index);
			for (c = 0; c < 3; c++) begin
				if (hit[k])
					sv = cfg_from[c];
				else
					sv = $signed(t.coord[3 * k + c]);
				pt[k][c] = sv;
			end
		end
		v.touches = |hit;
		if (!v.touches)
			return v;
		na = normal_of(pt[0], pt[1], pt[2]);
		// only the first matching corner moves
		for (k = 2; k >= 0; k--)
			if (hit[k])
				first = k;
		for (c = 0; c < 3; c++) begin
			sv = cfg_to[c];
			pt[first][c] = sv;
		end
		nb = normal_of(pt[0], pt[1], pt[2]);
		if (na == '0 || nb == '0)
			return v;
		dot = '0;
		len_a = '0;
		len_b = '0;
		for (c = 0; c < 3; c++) begin
			wa = $signed(na[c]);
			wb = $signed(nb[c]);
			dot += wa * wb;
			len_a += wa * wa;
			len_b += wb * wb;
		end
		if (dot < 0)
			v.flips = 1'b1;
		else
			v.flips = (25 * dot * dot < len_a * len_b);
		return v;
	endfunction

	function automatic int idle_span();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int rnd_coord(int span);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return -32768;
		if (r == 1)
			return 32767;
		if (span >= 32767)
			return int'($urandom_range(0, 65535)) - 32768;
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [INDEX_W-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		case (idx)
			REG_MOVING_INDEX: cfg_index = data;
			REG_OLD_X:        cfg_from[0] = data[COORD_W-1:0];
			REG_OLD_Y:        cfg_from[1] = data[COORD_W-1:0];
			REG_OLD_Z:        cfg_from[2] = data[COORD_W-1:0];
			REG_NEW_X:        cfg_to[0] = data[COORD_W-1:0];
			REG_NEW_Y:        cfg_to[1] = data[COORD_W-1:0];
			REG_NEW_Z:        cfg_to[2] = data[COORD_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// upper data bits are junk for the coordinate registers
	task automatic set_mover(input logic [INDEX_W-1:0] idx, input int ox, oy, oz, nx, ny, nz);
		write_reg(REG_MOVING_INDEX, idx);
		write_reg(REG_OLD_X, {8'($urandom), 16'(ox)});
		write_reg(REG_OLD_Y, {8'($urandom), 16'(oy)});
		write_reg(REG_OLD_Z, {8'($urandom), 16'(oz)});
		write_reg(REG_NEW_X, {8'($urandom), 16'(nx)});
		write_reg(REG_NEW_Y, {8'($urandom), 16'(ny)});
		write_reg(REG_NEW_Z, {8'($urandom), 16'(nz)});
	endtask

	task automatic add_tri(input logic [INDEX_W-1:0] a, b, d,
			input int x0, y0, z0, x1, y1, z1, x2, y2, z2);
		triangle_t t;
		t.corner = {d, b, a};
		t.coord = {16'(z2), 16'(y2), 16'(x2), 16'(z1), 16'(y1), 16'(x1),
			16'(z0), 16'(y0), 16'(x0)};
		triangle_queue.insert(triangle_queue.size(), t);
	endtask

	task automatic wait_idle();
		while (triangle_queue.size() != 0 || in_valid || verdict_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int count);
		logic [INDEX_W-1:0] idx;
		triangle_t          t;
		int                 span, n, k, i;
		int                 o [3];
		int                 m [3];
		idx = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom_range(0, 7)) : INDEX_W'($urandom);
		span = ($urandom_range(0, 3) == 0) ? 32767 : 1024;
		for (i = 0; i < 3; i++) begin
			o[i] = rnd_coord(span);
			// keep the move small now and then so that few triangles flip
			if (span < 32767 && $urandom_range(0, 1) == 1 && o[i] > -32000 && o[i] < 32000)
				m[i] = o[i] + int'($urandom_range(0, 64)) - 32;
			else
				m[i] = rnd_coord(span);
		end
		set_mover(idx, o[0], o[1], o[2], m[0], m[1], m[2]);
		for (n = 0; n < count; n++) begin
			for (k = 0; k < 3; k++)
				t.corner[k] = ($urandom_range(0, 1) == 1) ? INDEX_W'($urandom_range(0, 7))
					: INDEX_W'($urandom);
			if ($urandom_range(0, 9) < 8) begin
				k = $urandom_range(0, 2);
				t.corner[k] = idx;
				if ($urandom_range(0, 7) == 0)
					t.corner[(k + 1) % 3] = idx;
				if ($urandom_range(0, 15) == 0)
					t.corner = {idx, idx, idx};
			end
			for (i = 0; i < 9; i++)
				t.coord[i] = 16'(rnd_coord(span));
			triangle_queue.insert(triangle_queue.size(), t);
		end
	endtask

	// input driver
	always @(negedge clk) begin
		if (!in_valid || tri_taken) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (triangle_queue.size() > 0) begin
				on_bus = triangle_queue.pop_front();
				first_corner <= on_bus.corner[0];
				second_corner <= on_bus.corner[1];
				third_corner <= on_bus.corner[2];
				first_px <= on_bus.coord[0];
				first_py <= on_bus.coord[1];
				first_pz <= on_bus.coord[2];
				second_px <= on_bus.coord[3];
				second_py <= on_bus.coord[4];
				second_pz <= on_bus.coord[5];
				third_px <= on_bus.coord[6];
				third_py <= on_bus.coord[7];
				third_pz <= on_bus.coord[8];
				in_valid <= 1'b1;
				in_gap = idle_span();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result stall
	always @(negedge clk) begin
		if (out_hold > 0) begin
			out_stall <= 1'b1;
			out_hold--;
		end else begin
			out_stall <= 1'b0;
			out_hold = idle_span();
		end
	end

	// monitor
	always @(posedge clk) begin
		cycle_count++;
		tri_taken = arst_n && in_valid && !in_stall;
		if (tri_taken)
			verdict_queue.insert(verdict_queue.size(), judge_triangle(on_bus));
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("cycle %0d: result flips=%b touches=%b with no transaction pending",
						cycle_count, flips, touches_mover);
			end else begin
				want = verdict_queue.pop_front();
				if (flips !== want.flips || touches_mover !== want.touches) begin
					mismatches++;
					if (mismatches <= 10)
						$display("cycle %0d: flips exp %b got %b, touches_mover exp %b got %b",
							cycle_count, want.flips, flips, want.touches, touches_mover);
				end
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		first_corner = '0;
		second_corner = '0;
		third_corner = '0;
		{first_px, first_py, first_pz} = '0;
		{second_px, second_py, second_pz} = '0;
		{third_px, third_py, third_pz} = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		cfg_index = '0;
		cfg_from = '{default: '0};
		cfg_to = '{default: '0};
		on_bus = '0;
		tri_taken = 1'b0;
		no_idle = 1'b0;
		in_gap = 0;
		out_hold = 0;
		mismatches = 0;
		cycle_count = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// registers straight out of reset: corner zero is the mover, not moving
		add_tri(0, 1, 2, 0, 0, 0, 256, 0, 0, 0, 256, 0);
		wait_idle();

		set_mover(5, 0, 0, 0, 128, 128, 256);
		write_reg(REG_UNUSED, 24'hFFFFFF);
		add_tri(1, 2, 3, 100, -200, 300, -4, 5, 6, 7, 8, -9);
		// normals at right angles
		add_tri(5, 6, 7, 999, -999, 77, 256, 0, 0, 0, 256, 0);
		add_tri(6, 5, 7, 256, 0, 0, 1, 2, 3, 0, 256, 0);
		add_tri(6, 7, 5, 256, 0, 0, 0, 256, 0, -1, -1, -1);
		// flat before the move, then flat after it
		add_tri(5, 6, 7, 0, 0, 0, 256, 0, 0, 512, 0, 0);
		add_tri(5, 6, 7, 0, 0, 0, 128, 128, 256, 0, 256, 0);
		// mover on more than one corner
		add_tri(5, 5, 7, 0, 0, 0, 0, 0, 0, 0, 256, 0);
		add_tri(5, 5, 5, 1, 2, 3, 4, 5, 6, 7, 8, 9);
		add_tri(7, 5, 5, 256, 0, 0, 0, 0, 0, 0, 0, 0);
		add_tri(5, 6, 7, 0, 0, 0, 0, 256, 0, 256, 0, 0);
		wait_idle();

		set_mover(24'hFFFFFF, -32768, -32768, -32768, 32767, 32767, 32767);
		add_tri(24'hFFFFFF, 0, 24'hFFFFFE, 0, 0, 0, 32767, -32768, 32767,
			-32768, 32767, -32768);
		add_tri(0, 24'hFFFFFF, 24'h7FFFFF, 32767, 32767, -32768, 0, 0, 0,
			-32768, -32768, 32767);
		add_tri(0, 24'h800000, 24'hFFFFFF, 32767, -32768, 0, 0, 32767, -32768, 0, 0, 0);
		add_tri(0, 24'hAAAAAA, 24'h555555, -32768, 32767, -32768, 32767, -32768, 32767,
			-1, 0, 1);
		wait_idle();

		set_mover(0, 32767, 32767, 32767, -32768, -32768, -32768);
		add_tri(0, 1, 2, 0, 0, 0, -32768, 32767, 0, 0, -32768, 32767);
		add_tri(1, 0, 2, -32768, -32768, 32767, 0, 0, 0, 32767, 0, -32768);
		wait_idle();

		// small move: normal barely turns
		set_mover(0, 0, 0, 0, 16, 8, 4);
		add_tri(0, 1, 2, 0, 0, 0, 256, 0, 0, 0, 256, 0);
		add_tri(0, 1, 2, 0, 0, 0, 0, 256, 0, 256, 0, 0);
		wait_idle();

		for (int p = 0; p < 7; p++) begin
			no_idle = (p == 2 || p == 5);
			random_phase(100);
			wait_idle();
		end

		if (mismatches == 0 && verdict_queue.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
rtl/tfc_pkg.sv
rtl/tfc_mul34.sv
rtl/tfc_mul72.sv
rtl/triangle_flip_check.sv
bench/testbench.sv
